@@ rtl/core/tvw_pkg.sv @@
package tvw_pkg;

    // geometry and stack sizing
    localparam int STACK_DEPTH = 16;
    localparam int FRAC_BITS   = 8;
    localparam int STACK_AW    = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
    localparam int CNT_W       = $clog2(STACK_DEPTH + 1);

    // field widths
    localparam int ACT_W     = 3;
    localparam int DIST_W    = 24;
    localparam int HEAD_W    = 16;
    localparam int POS_W     = 32;
    localparam int LW_W      = 8;
    localparam int FLT_W     = 2;
    localparam int IN_DATA_W = DIST_W + HEAD_W;
    localparam int RES_W     = 8 * POS_W;
    localparam int OUT_USER_W = FLT_W + 1;

    // trig and step arithmetic
    localparam int TRIG_W     = 20;
    localparam int TRIG_FRAC  = 16;
    localparam int Z_W        = 18;
    localparam int PROD_W     = DIST_W + TRIG_W;
    localparam int STEP_W     = PROD_W - TRIG_FRAC;
    localparam int SUM_W      = POS_W + 2;
    localparam int ROUND_HALF = 1 << (TRIG_FRAC - 1);

    localparam int CORDIC_STEPS = 16;
    localparam int CORDIC_GAIN  = 39797;
    localparam int STEP_IW      = $clog2(CORDIC_STEPS);
    localparam int ITER_N       = CORDIC_STEPS / 2;
    localparam int ITER_W       = $clog2(ITER_N);
    localparam int QUARTER_TURN = 16384;
    localparam int HALF_TURN    = 32768;
    localparam int HOME_HEADING = QUARTER_TURN;

    localparam logic signed [SUM_W-1:0] POS_MAX_S = (SUM_W'(1) <<< (POS_W - 1)) - SUM_W'(1);
    localparam logic signed [SUM_W-1:0] POS_MIN_S = -(SUM_W'(1) <<< (POS_W - 1));

    typedef enum logic [ACT_W-1:0] {
        ACT_MOVE     = 3'd0,
        ACT_LEFT     = 3'd1,
        ACT_RIGHT    = 3'd2,
        ACT_SAVE     = 3'd3,
        ACT_RESTORE  = 3'd4,
        ACT_PEN_DOWN = 3'd5,
        ACT_PEN_UP   = 3'd6,
        ACT_HOME     = 3'd7
    } t_action;

    typedef enum logic [FLT_W-1:0] {
        FLT_NONE  = 2'd0,
        FLT_FULL  = 2'd1,
        FLT_EMPTY = 2'd2
    } t_fault;

    typedef enum logic {
        ST_IDLE,
        ST_EXEC
    } t_eng_state;

    typedef struct packed {
        t_action                   action;
        logic signed [DIST_W-1:0]  distance;
        logic signed [HEAD_W-1:0]  turn_angle;
    } t_cmd;

    typedef struct packed {
        logic        [HEAD_W-1:0] heading;
        logic signed [POS_W-1:0]  y;
        logic signed [POS_W-1:0]  x;
    } t_pose;

    typedef struct packed {
        logic signed [POS_W-1:0] max_y;
        logic signed [POS_W-1:0] max_x;
        logic signed [POS_W-1:0] min_y;
        logic signed [POS_W-1:0] min_x;
    } t_box;

    // packed so that start_x lands in the lowest bits of tdata
    typedef struct packed {
        t_box                    box;
        logic signed [POS_W-1:0] end_y;
        logic signed [POS_W-1:0] end_x;
        logic signed [POS_W-1:0] start_y;
        logic signed [POS_W-1:0] start_x;
    } t_result;

    typedef struct packed {
        logic                     done;
        logic signed [TRIG_W-1:0] cos_v;
        logic signed [TRIG_W-1:0] sin_v;
    } t_trig;

endpackage

@@ rtl/core/turtle_vector_walker.sv @@
// Turtle-graphics walker: one command in on the slave stream, one result out on the master
// stream for every command. A command is handled in a first step that reads the pose stack
// RAM and forms distance times cos and sin, and a second step that, once the output register
// is free, commits the pose, stack and bounding box and loads the output register; a new
// command is taken only after that commit, while the previous result may still wait
// downstream. cos and sin come from an iterative CORDIC that runs two micro-rotations per
// cycle; it restarts after reset and after every turn, successful restore and home, and a
// move right behind one of those waits until the CORDIC is done. The pose stack RAM needs
// no clearing pass, so commands other than a move are taken right after reset. line_width
// may be written at any time the block holds no command.
module turtle_vector_walker (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              s_axis_tvalid,
    output logic                              s_axis_tready,
    input  logic [tvw_pkg::IN_DATA_W-1:0]     s_axis_tdata,   // distance, turn_angle
    input  logic [tvw_pkg::ACT_W-1:0]         s_axis_tuser,   // action
    output logic                              m_axis_tvalid,
    input  logic                              m_axis_tready,
    output logic [tvw_pkg::RES_W-1:0]         m_axis_tdata,   // start_x, start_y, end_x, end_y,
                                                              // box_min_x, box_min_y,
                                                              // box_max_x, box_max_y
    output logic [tvw_pkg::OUT_USER_W-1:0]    m_axis_tuser,   // drew, fault
    input  logic                              i_cfg_valid,
    output logic                              o_cfg_ready,
    input  logic [tvw_pkg::LW_W-1:0]          i_cfg_data      // line_width
);

    tvw_pkg::t_eng_state r_state, n_state;
    logic                take, commit, out_free, in_xfer;

    logic                r_in_valid;
    tvw_pkg::t_cmd       r_in, n_in, r_cmd;

    logic signed [tvw_pkg::POS_W-1:0]  r_pos_x, r_pos_y, n_pos_x, n_pos_y;
    logic [tvw_pkg::HEAD_W-1:0]        r_heading, n_heading;
    logic                              r_pen, n_pen;
    logic [tvw_pkg::CNT_W-1:0]         r_count, n_count;
    tvw_pkg::t_box                     r_box, n_box, r_pre, n_pre;
    logic [tvw_pkg::LW_W-1:0]          r_line_width;

    logic signed [tvw_pkg::PROD_W-1:0] r_prod_x, r_prod_y, n_prod_x, n_prod_y;
    logic                              r_trig_ok, r_boot;
    logic                              trig_start, heading_chg;
    logic [tvw_pkg::HEAD_W-1:0]        trig_heading;
    tvw_pkg::t_trig                    trig;

    logic                              ram_we, want_write;
    logic [tvw_pkg::STACK_AW-1:0]      ram_waddr, ram_raddr;
    logic [$bits(tvw_pkg::t_pose)-1:0] ram_wdata, ram_rdata;
    tvw_pkg::t_pose                    rd_pose, wr_pose;
    logic [tvw_pkg::CNT_W-1:0]         cnt_dec;

    logic                              r_out_valid;
    tvw_pkg::t_result                  r_out;
    logic [tvw_pkg::OUT_USER_W-1:0]    r_out_user;
    logic                              drew;
    tvw_pkg::t_fault                   fault;

    logic signed [tvw_pkg::SUM_W-1:0]  n_pad, pos_ext_x, pos_ext_y;
    logic signed [tvw_pkg::STEP_W-1:0] step_x, step_y;
    logic signed [tvw_pkg::SUM_W-1:0]  sum_x, sum_y, sum_lo_x, sum_lo_y, sum_hi_x, sum_hi_y;
    logic signed [tvw_pkg::POS_W-1:0]  new_x, new_y, lo_x, lo_y, hi_x, hi_y;

    function automatic logic signed [tvw_pkg::POS_W-1:0] sat_pos(
        input logic signed [tvw_pkg::SUM_W-1:0] v
    );
        logic signed [tvw_pkg::POS_W-1:0] r;
        if (v > tvw_pkg::POS_MAX_S) begin
            r = tvw_pkg::POS_MAX_S[tvw_pkg::POS_W-1:0];
        end else if (v < tvw_pkg::POS_MIN_S) begin
            r = tvw_pkg::POS_MIN_S[tvw_pkg::POS_W-1:0];
        end else begin
            r = v[tvw_pkg::POS_W-1:0];
        end
        return r;
    endfunction

    function automatic logic signed [tvw_pkg::POS_W-1:0] smin(
        input logic signed [tvw_pkg::POS_W-1:0] a,
        input logic signed [tvw_pkg::POS_W-1:0] b
    );
        return (a < b) ? a : b;
    endfunction

    function automatic logic signed [tvw_pkg::POS_W-1:0] smax(
        input logic signed [tvw_pkg::POS_W-1:0] a,
        input logic signed [tvw_pkg::POS_W-1:0] b
    );
        return (a > b) ? a : b;
    endfunction

    // input holding register
    assign in_xfer       = s_axis_tvalid && s_axis_tready;
    assign s_axis_tready = !r_in_valid || take;

    assign n_in.action     = tvw_pkg::t_action'(s_axis_tuser);
    assign n_in.distance   = s_axis_tdata[tvw_pkg::DIST_W-1:0];
    assign n_in.turn_angle = s_axis_tdata[tvw_pkg::IN_DATA_W-1:tvw_pkg::DIST_W];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (in_xfer) begin
            r_in_valid <= 1'b1;
        end else if (take) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_xfer) begin
            r_in <= n_in;
        end
    end

    // sequencer
    assign out_free = !r_out_valid || m_axis_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= tvw_pkg::ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        take    = 1'b0;
        commit  = 1'b0;
        unique case (r_state)
            tvw_pkg::ST_IDLE: begin
                // a move waits until cos and sin match the current heading
                if (r_in_valid && (r_in.action != tvw_pkg::ACT_MOVE || r_trig_ok)) begin
                    take    = 1'b1;
                    n_state = tvw_pkg::ST_EXEC;
                end
            end
            tvw_pkg::ST_EXEC: begin
                if (out_free) begin
                    commit  = 1'b1;
                    n_state = tvw_pkg::ST_IDLE;
                end
            end
        endcase
    end

    // first cycle: products and the box widened around the old position
    assign n_prod_x = tvw_pkg::PROD_W'(r_in.distance) * tvw_pkg::PROD_W'(trig.cos_v)
                    + tvw_pkg::PROD_W'(tvw_pkg::ROUND_HALF);
    assign n_prod_y = tvw_pkg::PROD_W'(r_in.distance) * tvw_pkg::PROD_W'(trig.sin_v)
                    + tvw_pkg::PROD_W'(tvw_pkg::ROUND_HALF);

    assign n_pad     = $signed(tvw_pkg::SUM_W'(r_line_width >> 1) << tvw_pkg::FRAC_BITS);
    assign pos_ext_x = tvw_pkg::SUM_W'(r_pos_x);
    assign pos_ext_y = tvw_pkg::SUM_W'(r_pos_y);

    assign n_pre.min_x = smin(r_box.min_x, sat_pos(pos_ext_x - n_pad));
    assign n_pre.min_y = smin(r_box.min_y, sat_pos(pos_ext_y - n_pad));
    assign n_pre.max_x = smax(r_box.max_x, sat_pos(pos_ext_x + n_pad));
    assign n_pre.max_y = smax(r_box.max_y, sat_pos(pos_ext_y + n_pad));

    always_ff @(posedge i_clk) begin
        if (take) begin
            r_cmd    <= r_in;
            r_prod_x <= n_prod_x;
            r_prod_y <= n_prod_y;
            r_pre    <= n_pre;
        end
    end

    // second cycle: new position and the box around it
    assign step_x   = r_prod_x[tvw_pkg::PROD_W-1:tvw_pkg::TRIG_FRAC];
    assign step_y   = r_prod_y[tvw_pkg::PROD_W-1:tvw_pkg::TRIG_FRAC];
    assign sum_x    = pos_ext_x + tvw_pkg::SUM_W'(step_x);
    assign sum_y    = pos_ext_y + tvw_pkg::SUM_W'(step_y);
    assign sum_lo_x = pos_ext_x + tvw_pkg::SUM_W'(step_x) - n_pad;
    assign sum_lo_y = pos_ext_y + tvw_pkg::SUM_W'(step_y) - n_pad;
    assign sum_hi_x = pos_ext_x + tvw_pkg::SUM_W'(step_x) + n_pad;
    assign sum_hi_y = pos_ext_y + tvw_pkg::SUM_W'(step_y) + n_pad;
    assign new_x    = sat_pos(sum_x);
    assign new_y    = sat_pos(sum_y);

    // pad applies to the saturated position, so clamp first where the sum ran out of range
    assign lo_x = (sum_x > tvw_pkg::POS_MAX_S) ? sat_pos(tvw_pkg::POS_MAX_S - n_pad)
                                               : sat_pos(sum_lo_x);
    assign lo_y = (sum_y > tvw_pkg::POS_MAX_S) ? sat_pos(tvw_pkg::POS_MAX_S - n_pad)
                                               : sat_pos(sum_lo_y);
    assign hi_x = (sum_x < tvw_pkg::POS_MIN_S) ? sat_pos(tvw_pkg::POS_MIN_S + n_pad)
                                               : sat_pos(sum_hi_x);
    assign hi_y = (sum_y < tvw_pkg::POS_MIN_S) ? sat_pos(tvw_pkg::POS_MIN_S + n_pad)
                                               : sat_pos(sum_hi_y);

    assign rd_pose = tvw_pkg::t_pose'(ram_rdata);
    assign cnt_dec = r_count - tvw_pkg::CNT_W'(1);

    always_comb begin
        n_pos_x     = r_pos_x;
        n_pos_y     = r_pos_y;
        n_heading   = r_heading;
        n_pen       = r_pen;
        n_count     = r_count;
        n_box       = r_box;
        drew        = 1'b0;
        fault       = tvw_pkg::FLT_NONE;
        want_write  = 1'b0;
        heading_chg = 1'b0;
        unique case (r_cmd.action)
            tvw_pkg::ACT_MOVE: begin
                n_pos_x     = new_x;
                n_pos_y     = new_y;
                n_box.min_x = smin(r_pre.min_x, lo_x);
                n_box.min_y = smin(r_pre.min_y, lo_y);
                n_box.max_x = smax(r_pre.max_x, hi_x);
                n_box.max_y = smax(r_pre.max_y, hi_y);
                drew        = r_pen;
            end
            tvw_pkg::ACT_LEFT: begin
                n_heading   = r_heading + $unsigned(r_cmd.turn_angle);
                heading_chg = 1'b1;
            end
            tvw_pkg::ACT_RIGHT: begin
                n_heading   = r_heading - $unsigned(r_cmd.turn_angle);
                heading_chg = 1'b1;
            end
            tvw_pkg::ACT_SAVE: begin
                if (r_count == tvw_pkg::CNT_W'(tvw_pkg::STACK_DEPTH)) begin
                    fault = tvw_pkg::FLT_FULL;
                end else begin
                    want_write = 1'b1;
                    n_count    = r_count + tvw_pkg::CNT_W'(1);
                end
            end
            tvw_pkg::ACT_RESTORE: begin
                if (r_count == '0) begin
                    fault = tvw_pkg::FLT_EMPTY;
                end else begin
                    n_count     = cnt_dec;
                    n_pos_x     = rd_pose.x;
                    n_pos_y     = rd_pose.y;
                    n_heading   = rd_pose.heading;
                    heading_chg = 1'b1;
                end
            end
            tvw_pkg::ACT_PEN_DOWN: begin
                n_pen = 1'b1;
            end
            tvw_pkg::ACT_PEN_UP: begin
                n_pen = 1'b0;
            end
            tvw_pkg::ACT_HOME: begin
                n_pos_x     = '0;
                n_pos_y     = '0;
                n_heading   = tvw_pkg::HEAD_W'(tvw_pkg::HOME_HEADING);
                heading_chg = 1'b1;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos_x   <= '0;
            r_pos_y   <= '0;
            r_heading <= tvw_pkg::HEAD_W'(tvw_pkg::HOME_HEADING);
            r_pen     <= 1'b1;
            r_count   <= '0;
            r_box     <= '0;
        end else if (commit) begin
            r_pos_x   <= n_pos_x;
            r_pos_y   <= n_pos_y;
            r_heading <= n_heading;
            r_pen     <= n_pen;
            r_count   <= n_count;
            r_box     <= n_box;
        end
    end

    // pose stack: the read of the top entry is issued in the first cycle and used in the
    // second; a save writes at commit, before any later read can be issued
    assign wr_pose.x       = r_pos_x;
    assign wr_pose.y       = r_pos_y;
    assign wr_pose.heading = r_heading;
    assign ram_wdata       = wr_pose;
    assign ram_we          = commit && want_write;
    assign ram_waddr       = r_count[tvw_pkg::STACK_AW-1:0];
    assign ram_raddr       = cnt_dec[tvw_pkg::STACK_AW-1:0];

    tvw_ram #(
        .WIDTH ($bits(tvw_pkg::t_pose)),
        .DEPTH (tvw_pkg::STACK_DEPTH)
    ) u_stack_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    // trig unit restarts whenever the heading is rewritten
    assign trig_start   = r_boot || (commit && heading_chg);
    assign trig_heading = commit ? n_heading : r_heading;

    tvw_cordic u_cordic (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_start   (trig_start),
        .i_heading (trig_heading),
        .o_trig    (trig)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_boot    <= 1'b1;
            r_trig_ok <= 1'b0;
        end else begin
            r_boot <= 1'b0;
            if (trig_start) begin
                r_trig_ok <= 1'b0;
            end else if (trig.done) begin
                r_trig_ok <= 1'b1;
            end
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (commit) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (commit) begin
            r_out.start_x <= r_pos_x;
            r_out.start_y <= r_pos_y;
            r_out.end_x   <= n_pos_x;
            r_out.end_y   <= n_pos_y;
            r_out.box     <= n_box;
            r_out_user    <= {fault, drew};
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out;
    assign m_axis_tuser  = r_out_user;

    // line width register
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_line_width <= tvw_pkg::LW_W'(1);
        end else if (i_cfg_valid && o_cfg_ready) begin
            r_line_width <= i_cfg_data;
        end
    end

endmodule

@@ rtl/core/tvw_ram.sv @@
module tvw_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                                       i_clk,
    input  logic                                       i_we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                           i_wdata,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                           o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

@@ rtl/core/tvw_cordic.sv @@
module tvw_cordic (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_start,
    input  logic [tvw_pkg::HEAD_W-1:0]  i_heading,
    output tvw_pkg::t_trig              o_trig
);

    logic                               r_busy;
    logic                               r_done;
    logic [tvw_pkg::ITER_W-1:0]         r_iter;
    logic signed [tvw_pkg::TRIG_W-1:0]  r_x;
    logic signed [tvw_pkg::TRIG_W-1:0]  r_y;
    logic signed [tvw_pkg::Z_W-1:0]     r_z;

    logic signed [tvw_pkg::Z_W-1:0]     z_in;
    logic signed [tvw_pkg::Z_W-1:0]     z_fold;
    logic signed [tvw_pkg::TRIG_W-1:0]  x_fold;
    logic [tvw_pkg::STEP_IW-1:0]        idx0;
    logic [tvw_pkg::STEP_IW-1:0]        idx1;
    logic signed [tvw_pkg::TRIG_W-1:0]  x1, y1, x2, y2;
    logic signed [tvw_pkg::Z_W-1:0]     z1, z2;

    // arctan(2^-i) in binary angle units
    function automatic logic signed [tvw_pkg::Z_W-1:0] atan_unit(
        input logic [tvw_pkg::STEP_IW-1:0] idx
    );
        logic signed [tvw_pkg::Z_W-1:0] v;
        unique case (idx)
            4'd0:    v = tvw_pkg::Z_W'(8192);
            4'd1:    v = tvw_pkg::Z_W'(4836);
            4'd2:    v = tvw_pkg::Z_W'(2555);
            4'd3:    v = tvw_pkg::Z_W'(1297);
            4'd4:    v = tvw_pkg::Z_W'(651);
            4'd5:    v = tvw_pkg::Z_W'(326);
            4'd6:    v = tvw_pkg::Z_W'(163);
            4'd7:    v = tvw_pkg::Z_W'(81);
            4'd8:    v = tvw_pkg::Z_W'(41);
            4'd9:    v = tvw_pkg::Z_W'(20);
            4'd10:   v = tvw_pkg::Z_W'(10);
            4'd11:   v = tvw_pkg::Z_W'(5);
            4'd12:   v = tvw_pkg::Z_W'(3);
            4'd13:   v = tvw_pkg::Z_W'(1);
            4'd14:   v = tvw_pkg::Z_W'(1);
            default: v = '0;
        endcase
        return v;
    endfunction

    // fold the heading into the right half plane, flipping the start vector
    always_comb begin
        z_in = tvw_pkg::Z_W'($signed(i_heading));
        if (z_in > tvw_pkg::Z_W'(tvw_pkg::QUARTER_TURN)) begin
            z_fold = z_in - tvw_pkg::Z_W'(tvw_pkg::HALF_TURN);
            x_fold = -tvw_pkg::TRIG_W'(tvw_pkg::CORDIC_GAIN);
        end else if (z_in < -tvw_pkg::Z_W'(tvw_pkg::QUARTER_TURN)) begin
            z_fold = z_in + tvw_pkg::Z_W'(tvw_pkg::HALF_TURN);
            x_fold = -tvw_pkg::TRIG_W'(tvw_pkg::CORDIC_GAIN);
        end else begin
            z_fold = z_in;
            x_fold = tvw_pkg::TRIG_W'(tvw_pkg::CORDIC_GAIN);
        end
    end

    // two micro-rotations per cycle
    always_comb begin
        idx0 = {r_iter, 1'b0};
        idx1 = {r_iter, 1'b1};
        if (r_z >= 0) begin
            x1 = r_x - (r_y >>> idx0);
            y1 = r_y + (r_x >>> idx0);
            z1 = r_z - atan_unit(idx0);
        end else begin
            x1 = r_x + (r_y >>> idx0);
            y1 = r_y - (r_x >>> idx0);
            z1 = r_z + atan_unit(idx0);
        end
        if (z1 >= 0) begin
            x2 = x1 - (y1 >>> idx1);
            y2 = y1 + (x1 >>> idx1);
            z2 = z1 - atan_unit(idx1);
        end else begin
            x2 = x1 + (y1 >>> idx1);
            y2 = y1 - (x1 >>> idx1);
            z2 = z1 + atan_unit(idx1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_iter <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_iter <= '0;
            end else if (r_busy) begin
                r_iter <= r_iter + tvw_pkg::ITER_W'(1);
                if (r_iter == tvw_pkg::ITER_W'(tvw_pkg::ITER_N - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_x <= x_fold;
            r_y <= '0;
            r_z <= z_fold;
        end else if (r_busy) begin
            r_x <= x2;
            r_y <= y2;
            r_z <= z2;
        end
    end

    assign o_trig.done  = r_done;
    assign o_trig.cos_v = r_x;
    assign o_trig.sin_v = r_y;

endmodule

@@ rtl/core/tvw_checker.sv @@
module tvw_checker (
    input logic                              i_clk,
    input logic                              i_rst_n,
    input logic                              m_axis_tvalid,
    input logic                              m_axis_tready,
    input logic [tvw_pkg::RES_W-1:0]         m_axis_tdata,
    input logic [tvw_pkg::OUT_USER_W-1:0]    m_axis_tuser
);

    // stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=>
            m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
        else $error("result changed while stalled");

    // a drawn segment never comes with a stack fault
    a_drew_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tuser[0] |-> m_axis_tuser[2:1] == tvw_pkg::FLT_NONE)
        else $error("segment reported together with a fault");

    // a faulted save or restore leaves the position alone
    a_fault_still: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tuser[2:1] != tvw_pkg::FLT_NONE |->
            m_axis_tdata[95:64] == m_axis_tdata[31:0] &&
            m_axis_tdata[127:96] == m_axis_tdata[63:32])
        else $error("faulted command moved the turtle");

    // the box starts at the origin and only grows
    a_box_origin: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |->
            $signed(m_axis_tdata[159:128]) <= 0 && $signed(m_axis_tdata[191:160]) <= 0 &&
            $signed(m_axis_tdata[223:192]) >= 0 && $signed(m_axis_tdata[255:224]) >= 0)
        else $error("bounding box lost the origin");

endmodule

bind turtle_vector_walker tvw_checker u_tvw_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
);
